>>> rtl/kli_pkg.sv
// Shared types, codes and widths for the keyframe linear interpolator.
package kli_pkg;

    // Field widths fixed by the stream format
    localparam int TIME_W  = 32;
    localparam int VAL_W   = 32;
    localparam int SLOT_W  = 6;
    localparam int SEG_W   = 6;
    localparam int CFG_W   = 7;
    localparam int FRAC_W  = 16;

    // Packed stream widths (whole bytes)
    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 104;

    // Item kinds carried on s_tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Three-component key vector, x in the low bits
    typedef struct packed {
        logic signed [VAL_W-1:0] z;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] x;
    } vec_t;

    // Query sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SEARCH,
        ST_DIV,
        ST_LERP,
        ST_OUT
    } state_t;

endpackage

>>> rtl/kli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/kli_div.sv
// Serial restoring divider producing the Q0.16 blend factor, one bit a cycle.
module kli_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [kli_pkg::TIME_W-1:0]   num,
    input  logic [kli_pkg::TIME_W-1:0]   den,
    output logic [kli_pkg::FRAC_W-1:0]   quot,
    output logic                         done
);

    localparam int CNT_W = $clog2(kli_pkg::FRAC_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [kli_pkg::TIME_W-1:0]   rem_reg, rem_next;
    logic [kli_pkg::TIME_W-1:0]   den_reg, den_next;
    logic [kli_pkg::FRAC_W-1:0]   quot_reg, quot_next;
    logic [kli_pkg::TIME_W:0]     shifted;
    logic                         ge;

    // One restoring step: shift remainder, trial subtract
    assign shifted = {rem_reg, 1'b0};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(kli_pkg::FRAC_W - 1);
            rem_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? kli_pkg::TIME_W'(shifted - {1'b0, den_reg})
                           : shifted[kli_pkg::TIME_W-1:0];
            quot_next = {quot_reg[kli_pkg::FRAC_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Advance datapath
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

`ifndef SYNTHESIS
    // Done is never raised while a division is still running
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy_reg)
        else $error("divider done while still busy");
    // A start never lands on a running division
    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("divider restarted while busy");
    // A division always finishes with done
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg == '0 |=> done)
        else $error("divider missed done");
`endif

endmodule

>>> rtl/keyframe_linear_interpolator.sv
// Top level: key tables, query sequencer and shared multiply-add of the interpolator.
//
// A load beat (s_tuser = 0) writes one key into the key memories and returns
// nothing. A query beat (s_tuser = 1) reads key 0 as it is accepted, the search
// then walks the single-read-port key memory one key a cycle until it finds the
// first key time above the query, the 16-step serial divider forms the blend
// factor, and one shared multiplier blends x, y and z in turn. A query at or
// past the last key is clamped to it. Queries clamped before the first key, or
// with one key in use, finish after the first key read. The block takes no beat
// while a query is in flight or its result waits on m_tready. Times in the key
// table are expected in ascending order; entries read by a query must have been
// loaded.
module keyframe_linear_interpolator #(
    parameter int MAX_KEYS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Key count register write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kli_pkg::CFG_W-1:0]     cfg_data,    // keys_in_use
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key_slot[5:0], key_time[37:6], key_x[69:38], key_y[101:70], key_z[133:102],
    // query_time[165:134], zero fill
    input  logic [kli_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,     // op
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], segment[101:96], zero fill
    output logic [kli_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser      // clamped
);

    localparam int AW    = $clog2(MAX_KEYS);
    localparam int CW    = $clog2(MAX_KEYS + 1);
    localparam int VEC_W = $bits(kli_pkg::vec_t);
    localparam int PROD_W = kli_pkg::FRAC_W + 1 + kli_pkg::VAL_W + 1;

    // Unpack input beat
    logic [kli_pkg::SLOT_W-1:0] key_slot;
    logic [kli_pkg::TIME_W-1:0] key_time;
    logic [kli_pkg::TIME_W-1:0] query_time;
    kli_pkg::vec_t              key_vec;

    assign key_slot   = s_tdata[5:0];
    assign key_time   = s_tdata[37:6];
    assign key_vec.x  = s_tdata[69:38];
    assign key_vec.y  = s_tdata[101:70];
    assign key_vec.z  = s_tdata[133:102];
    assign query_time = s_tdata[165:134];

    kli_pkg::state_t state_reg, state_next;

    logic [kli_pkg::CFG_W-1:0]  kiu_reg;
    logic [CW-1:0]              n_reg, n_next;
    logic [kli_pkg::TIME_W-1:0] q_reg, q_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic [kli_pkg::TIME_W-1:0] prev_t_reg, prev_t_next;
    kli_pkg::vec_t              va_reg, va_next;
    kli_pkg::vec_t              vb_reg, vb_next;
    kli_pkg::vec_t              res_reg, res_next;
    logic [kli_pkg::SEG_W-1:0]  seg_reg, seg_next;
    logic                       clamp_reg, clamp_next;
    logic [1:0]                 comp_reg, comp_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;

    logic                       in_beat;
    logic                       load_we;
    logic [AW-1:0]              raddr;
    logic [kli_pkg::TIME_W-1:0] t_rdata;
    logic [VEC_W-1:0]           v_rdata_raw;
    kli_pkg::vec_t              v_rdata;
    logic [31:0]                kiu_ext;
    logic [31:0]                n_sel;

    logic                       div_start;
    logic [kli_pkg::FRAC_W-1:0] div_quot;
    logic                       div_done;

    logic signed [kli_pkg::VAL_W-1:0] ca, cb, cadd_a;
    logic signed [kli_pkg::VAL_W:0]   cdiff;
    logic signed [kli_pkg::VAL_W-1:0] csum;

    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == kli_pkg::ST_IDLE);
    assign m_tvalid  = (state_reg == kli_pkg::ST_OUT);
    assign m_tdata   = {2'b00, seg_reg, res_reg};
    assign m_tuser   = clamp_reg;

    // Write a key on a load beat to a slot inside the table
    assign load_we = in_beat && (s_tuser == kli_pkg::OP_LOAD)
                     && (32'(key_slot) < 32'(MAX_KEYS));

    kli_ram #(
        .WIDTH (kli_pkg::TIME_W),
        .DEPTH (MAX_KEYS)
    ) u_time_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(key_slot)),
        .wdata (key_time),
        .raddr (raddr),
        .rdata (t_rdata)
    );

    kli_ram #(
        .WIDTH (VEC_W),
        .DEPTH (MAX_KEYS)
    ) u_vec_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(key_slot)),
        .wdata (key_vec),
        .raddr (raddr),
        .rdata (v_rdata_raw)
    );

    assign v_rdata = v_rdata_raw;

    kli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (q_reg - prev_t_reg),
        .den   (t_rdata - prev_t_reg),
        .quot  (div_quot),
        .done  (div_done)
    );

    // Effective key count: zero acts as one, clip to table size
    assign kiu_ext = 32'(kiu_reg);
    assign n_sel   = (kiu_ext == 32'd0) ? 32'd1
                   : ((kiu_ext > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : kiu_ext);

    // Pick the component for the multiply (comp) and for the add (comp - 1)
    always_comb
    begin
        case (comp_reg)
            2'd0:
            begin
                ca = va_reg.x;
                cb = vb_reg.x;
            end
            2'd1:
            begin
                ca = va_reg.y;
                cb = vb_reg.y;
            end
            2'd2:
            begin
                ca = va_reg.z;
                cb = vb_reg.z;
            end
            default:
            begin
                ca = va_reg.z;
                cb = vb_reg.z;
            end
        endcase
        case (comp_reg)
            2'd1:    cadd_a = va_reg.x;
            2'd2:    cadd_a = va_reg.y;
            2'd3:    cadd_a = va_reg.z;
            default: cadd_a = va_reg.x;
        endcase
    end

    assign cdiff = {cb[kli_pkg::VAL_W-1], cb} - {ca[kli_pkg::VAL_W-1], ca};
    assign csum  = cadd_a + prod_reg[kli_pkg::FRAC_W +: kli_pkg::VAL_W];

    // Sequencer: next state, read address and datapath updates
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        q_next      = q_reg;
        idx_next    = idx_reg;
        prev_t_next = prev_t_reg;
        va_next     = va_reg;
        vb_next     = vb_reg;
        res_next    = res_reg;
        seg_next    = seg_reg;
        clamp_next  = clamp_reg;
        comp_next   = comp_reg;
        prod_next   = prod_reg;
        div_start   = 1'b0;
        raddr       = '0;
        case (state_reg)
            kli_pkg::ST_IDLE:
            begin
                // Key 0 is read while a query is taken
                if (in_beat && s_tuser == kli_pkg::OP_QUERY)
                begin
                    n_next     = CW'(n_sel);
                    q_next     = query_time;
                    state_next = kli_pkg::ST_FIRST;
                end
            end
            kli_pkg::ST_FIRST:
            begin
                raddr       = AW'(1);
                prev_t_next = t_rdata;
                va_next     = v_rdata;
                idx_next    = AW'(1);
                seg_next    = '0;
                res_next    = v_rdata;
                if (n_reg == CW'(1))
                begin
                    clamp_next = 1'b0;
                    state_next = kli_pkg::ST_OUT;
                end
                else if (q_reg < t_rdata)
                begin
                    clamp_next = 1'b1;
                    state_next = kli_pkg::ST_OUT;
                end
                else
                begin
                    state_next = kli_pkg::ST_SEARCH;
                end
            end
            kli_pkg::ST_SEARCH:
            begin
                raddr = idx_reg + 1'b1;
                if (q_reg < t_rdata)
                begin
                    // Segment found: start the factor division
                    vb_next    = v_rdata;
                    div_start  = 1'b1;
                    seg_next   = kli_pkg::SEG_W'(idx_reg - 1'b1);
                    clamp_next = 1'b0;
                    state_next = kli_pkg::ST_DIV;
                end
                else if (CW'(idx_reg) == n_reg - CW'(1))
                begin
                    // Past the last key: clamp to it
                    res_next   = v_rdata;
                    seg_next   = kli_pkg::SEG_W'(n_reg - CW'(2));
                    clamp_next = 1'b1;
                    state_next = kli_pkg::ST_OUT;
                end
                else
                begin
                    prev_t_next = t_rdata;
                    va_next     = v_rdata;
                    idx_next    = idx_reg + 1'b1;
                end
            end
            kli_pkg::ST_DIV:
            begin
                comp_next = 2'd0;
                if (div_done)
                begin
                    state_next = kli_pkg::ST_LERP;
                end
            end
            kli_pkg::ST_LERP:
            begin
                // Multiply component comp while adding component comp - 1
                if (comp_reg != 2'd3)
                begin
                    prod_next = $signed({1'b0, div_quot}) * cdiff;
                end
                case (comp_reg)
                    2'd1:    res_next.x = csum;
                    2'd2:    res_next.y = csum;
                    2'd3:    res_next.z = csum;
                    default: res_next   = res_reg;
                endcase
                comp_next = comp_reg + 1'b1;
                if (comp_reg == 2'd3)
                begin
                    state_next = kli_pkg::ST_OUT;
                end
            end
            kli_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = kli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kli_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold state and the key count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kli_pkg::ST_IDLE;
            kiu_reg   <= kli_pkg::CFG_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                kiu_reg <= cfg_data;
            end
        end
    end

    // Advance datapath registers
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        q_reg      <= q_next;
        idx_reg    <= idx_next;
        prev_t_reg <= prev_t_next;
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        res_reg    <= res_next;
        seg_reg    <= seg_next;
        clamp_reg  <= clamp_next;
        comp_reg   <= comp_next;
        prod_reg   <= prod_next;
    end

`ifndef SYNTHESIS
    // Never take a beat while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input accepted while result pending");
    // A query beat always starts with the first key read
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && s_tuser == kli_pkg::OP_QUERY |=> state_reg == kli_pkg::ST_FIRST)
        else $error("query did not start search");
    // Search index stays inside the keys in use
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kli_pkg::ST_SEARCH |-> idx_reg != '0 && CW'(idx_reg) < n_reg)
        else $error("search index out of range");
    // The divider reports done only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == kli_pkg::ST_DIV)
        else $error("unexpected divider done");
`endif

endmodule

>>> bench/tb_keyframe_linear_interpolator.sv
// Self-checking testbench for the keyframe linear interpolator: key loads, queries, key counts.
`timescale 1ns / 100ps

module tb_keyframe_linear_interpolator;

    localparam int KEY_SLOTS    = 64;
    localparam int RANDOM_BEATS = 1400;
    localparam int SETTLE       = 100;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int REPORT_MAX   = 10;

    // One sampled vector as the block returns it
    typedef struct packed {
        kli_pkg::vec_t v;
        logic [5:0]    seg;
        logic          clamped;
    } sample_t;

    // Key table shadow and queue of samples still owed by the block
    class key_sampler;
        logic [31:0]   key_times [KEY_SLOTS];
        kli_pkg::vec_t key_vecs [KEY_SLOTS];
        logic [6:0]    key_count;
        sample_t       expected_samples [$];
        int            mismatches;

        function new();
            key_count  = 7'd1;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        // Blend one component, rounding the step toward minus infinity
        function logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [16:0] f);
            longint d;
            longint fl;
            longint p;
            d  = longint'(signed'(b)) - longint'(signed'(a));
            fl = f;
            p  = fl * d;
            return a + p[47:16];
        endfunction

        // Update the table on a load, or work out the sample a query gives
        function void take_item(logic op, logic [5:0] slot, logic [31:0] t,
                                kli_pkg::vec_t v, logic [31:0] q);
            int          n;
            int          i;
            bit          found;
            sample_t     s;
            logic [63:0] num;
            logic [63:0] span;
            logic [16:0] f;
            if (op == kli_pkg::OP_LOAD)
            begin
                key_times[slot] = t;
                key_vecs[slot]  = v;
                return;
            end
            n = (key_count == 0) ? 1 : (key_count > KEY_SLOTS) ? KEY_SLOTS : key_count;
            s.v       = key_vecs[0];
            s.seg     = '0;
            s.clamped = 1'b0;
            if (n > 1 && q < key_times[0])
            begin
                s.clamped = 1'b1;
            end
            else if (n > 1)
            begin
                found = 1'b0;
                for (i = 0; i + 1 < n && !found; i++)
                begin
                    if (q < key_times[i+1])
                    begin
                        num   = {32'd0, q - key_times[i]} << 16;
                        span  = {32'd0, key_times[i+1]} - {32'd0, key_times[i]};
                        f     = 17'(num / span);
                        s.v.x = blend(key_vecs[i].x, key_vecs[i+1].x, f);
                        s.v.y = blend(key_vecs[i].y, key_vecs[i+1].y, f);
                        s.v.z = blend(key_vecs[i].z, key_vecs[i+1].z, f);
                        s.seg = 6'(i);
                        found = 1'b1;
                    end
                end
                // past the last key: hold the last vector
                if (!found)
                begin
                    s.v       = key_vecs[n-1];
                    s.seg     = 6'(n - 2);
                    s.clamped = 1'b1;
                end
            end
            expected_samples = {expected_samples, s};
        endfunction

        function void flag_error(string msg);
            if (mismatches < REPORT_MAX)
                $display("%s", msg);
            mismatches++;
        endfunction

        // Compare one result beat with the oldest owed sample
        function void check_sample(logic [kli_pkg::M_DATA_W-1:0] data, logic clamped);
            sample_t exp_s;
            sample_t got;
            got.v       = data[95:0];
            got.seg     = data[101:96];
            got.clamped = clamped;
            if (expected_samples.size() == 0)
            begin
                flag_error($sformatf("unexpected result x=%h y=%h z=%h seg=%0d clamped=%b",
                                     got.v.x, got.v.y, got.v.z, got.seg, got.clamped));
                return;
            end
            exp_s = expected_samples.pop_front();
            if (got.v.x !== exp_s.v.x || got.v.y !== exp_s.v.y || got.v.z !== exp_s.v.z ||
                got.seg !== exp_s.seg || got.clamped !== exp_s.clamped)
                flag_error($sformatf({"mismatch: expected x=%h y=%h z=%h seg=%0d clamped=%b,",
                                      " got x=%h y=%h z=%h seg=%0d clamped=%b"},
                                     exp_s.v.x, exp_s.v.y, exp_s.v.z, exp_s.seg, exp_s.clamped,
                                     got.v.x, got.v.y, got.v.z, got.seg, got.clamped));
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [kli_pkg::CFG_W-1:0]      cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [kli_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [kli_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           m_tuser;

    key_sampler sampler = new();
    bit         burst_mode = 1'b0;
    bit         hold_results = 1'b0;
    int         beats_sent = 0;

    keyframe_linear_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] rand_val();
        case ($urandom_range(7, 0))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(255, 0);
            default: return $urandom;
        endcase
    endfunction

    function automatic kli_pkg::vec_t rand_vec();
        kli_pkg::vec_t v;
        v.x = rand_val();
        v.y = rand_val();
        v.z = rand_val();
        return v;
    endfunction

    // Aim queries at key times, their neighbors, the covered range and the extremes
    function automatic logic [31:0] pick_query_time(int n);
        int          k;
        logic [31:0] lo;
        logic [31:0] hi;
        k  = $urandom_range(n - 1, 0);
        lo = sampler.key_times[0];
        hi = sampler.key_times[n-1];
        case ($urandom_range(7, 0))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return sampler.key_times[k];
            3: return sampler.key_times[k] - 32'd1;
            4: return sampler.key_times[k] + $urandom_range(3, 1);
            7: return $urandom;
            default: return (hi > lo) ? lo + ($urandom % (hi - lo)) : $urandom;
        endcase
    endfunction

    // Offer one input beat after a random gap and hold it until accepted
    task automatic push_beat(logic op, logic [5:0] slot, logic [31:0] t, kli_pkg::vec_t v,
                             logic [31:0] q);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(16, 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, q, v, t, slot};
        do @(posedge clk); while (!s_tready);
        sampler.take_item(op, slot, t, v, q);
        beats_sent++;
    endtask

    task automatic drive_key(logic [5:0] slot, logic [31:0] t, kli_pkg::vec_t v);
        push_beat(kli_pkg::OP_LOAD, slot, t, v, $urandom);
    endtask

    task automatic drive_query(logic [31:0] q);
        push_beat(kli_pkg::OP_QUERY, 6'($urandom_range(63, 0)), $urandom, rand_vec(), q);
    endtask

    // Drop valid, wait for every owed sample, then let the block go quiet
    task automatic halt_sender();
        s_tvalid <= 1'b0;
        while (sampler.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_key_count(logic [kli_pkg::CFG_W-1:0] count);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sampler.key_count = count;
    endtask

    // Load slots 0..n-1 with ascending (possibly equal) times
    task automatic load_ascending(int n);
        logic [31:0] t;
        logic [31:0] cap;
        int          i;
        t   = $urandom_range(32'h7FFF_FFFF, 0);
        cap = (32'hFFFF_FFFF - t) / n;
        case ($urandom_range(3, 0))
            0: cap = 32'd1;
            1: cap = 32'd64;
            2: cap = 32'd65536;
            default: ;
        endcase
        for (i = 0; i < n; i++)
        begin
            drive_key(6'(i), t, rand_vec());
            t = t + $urandom_range(cap, 0);
        end
    endtask

    function automatic logic [kli_pkg::CFG_W-1:0] corner_count(int k);
        case (k)
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd2;
            3: return 7'd64;
            4: return 7'd65;
            default: return 7'd127;
        endcase
    endfunction

    // Accept result beats after random stalls, with one long hold-off on request
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_results)
            begin
                hold_results = 1'b0;
                stall = LONG_HOLD;
            end
            else
                stall = burst_mode ? 0 : $urandom_range(16, 0);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sampler.check_sample(m_tdata, m_tuser);
        end
    end

    // End the run when no beat of any kind moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int                        phase_idx;
        int                        n_eff;
        int                        n_q;
        int                        j;
        int                        stop_at;
        logic [kli_pkg::CFG_W-1:0] count;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single key at reset count; vectors given as {z, y, x}
        drive_key(6'd0, 32'h0000_0100, {32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        drive_query(32'h0);
        drive_query(32'hFFFF_FFFF);
        // zero key count behaves as one key
        halt_sender();
        write_key_count(7'd0);
        drive_query($urandom);

        // Two keys with extreme values: before, at start, inside, at end, after
        drive_key(6'd1, 32'h0000_0300, {32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
        halt_sender();
        write_key_count(7'd2);
        drive_query(32'h0000_0050);
        drive_query(32'h0000_0100);
        drive_query(32'h0000_01FF);
        drive_query(32'h0000_02FF);
        drive_query(32'h0000_0300);
        drive_query(32'hFFFF_FFFF);

        // Third key earlier than the second: out-of-order times
        drive_key(6'd2, 32'h0000_0200, {32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0001});
        halt_sender();
        write_key_count(7'd3);
        drive_query(32'h0000_0250);
        drive_query(32'h0000_02FF);
        drive_query(32'h0000_0350);
        drive_key(6'd63, 32'hFFFF_FFFF, {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});

        // Fill every slot so any key count reads only loaded entries
        stop_at = beats_sent + RANDOM_BEATS;
        load_ascending(KEY_SLOTS);

        phase_idx = 0;
        while (beats_sent < stop_at)
        begin
            halt_sender();
            if (phase_idx < 6)
                count = corner_count(phase_idx);
            else
                case ($urandom_range(3, 0))
                    0: count = 7'($urandom_range(127, 0));
                    1: count = 7'($urandom_range(8, 2));
                    default: count = 7'($urandom_range(64, 2));
                endcase
            write_key_count(count);
            n_eff = (count == 0) ? 1 : (count > KEY_SLOTS) ? KEY_SLOTS : count;
            burst_mode = ($urandom_range(4, 0) == 0);

            // Reload a clean table, scramble a few keys, or keep the table
            case ($urandom_range(3, 0))
                0, 1: load_ascending(n_eff);
                2: repeat ($urandom_range(4, 1))
                       drive_key(6'($urandom_range(63, 0)), $urandom, rand_vec());
                default: ;
            endcase

            // Back up the result side once so the block stalls its input
            n_q = $urandom_range(24, 6);
            if (phase_idx == 3)
            begin
                hold_results = 1'b1;
                n_q = 30;
            end
            for (j = 0; j < n_q; j++)
            begin
                if ($urandom_range(9, 0) == 0)
                    drive_key(6'($urandom_range(63, 0)), $urandom, rand_vec());
                else
                    drive_query(pick_query_time(n_eff));
            end
            phase_idx++;
        end

        burst_mode = 1'b0;
        halt_sender();
        if (sampler.mismatches == 0 && sampler.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
